[design/point_range_gate_transform_voxelize_macros.svh]
// Assertion helpers used by the checker of this block
`ifndef POINT_RANGE_GATE_TRANSFORM_VOXELIZE_MACROS_SVH
`define POINT_RANGE_GATE_TRANSFORM_VOXELIZE_MACROS_SVH

// same-cycle implication, masked during reset
`define PRGTV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked during reset
`define PRGTV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, also checked across reset
`define PRGTV_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/prgtv_pkg.sv]
`timescale 1ns / 1ps

package prgtv_pkg;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int REG_IDX_W  = 3;

   localparam int RANGE_W = 47;
   localparam int INV_W   = 24;
   localparam int ROW_W   = 48;
   localparam int SHIFT_W = 24;
   localparam int ROT_W   = 16;
   localparam int NRM_W   = 16;
   localparam int WGT_W   = 16;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_MIN_RANGE_SQ,
      REG_MAX_RANGE_SQ,
      REG_INV_VOXEL_SIZE,
      REG_ROT_ROW_A,
      REG_ROT_ROW_B,
      REG_ROT_ROW_C,
      REG_SHIFT_XY,
      REG_SHIFT_Z
   } reg_idx_type;

   typedef struct packed {
      logic [RANGE_W-1:0]         min_range_sq;
      logic [RANGE_W-1:0]         max_range_sq;
      logic [INV_W-1:0]           inv_voxel_size;
      logic [2:0][ROW_W-1:0]      rot_rows;
      logic [ROW_W-1:0]           shift_xy;
      logic [SHIFT_W-1:0]         shift_z;
   } cfg_type;

   localparam logic [RANGE_W-1:0] RST_MIN_RANGE_SQ = '0;
   localparam logic [RANGE_W-1:0] RST_MAX_RANGE_SQ = '1;
   localparam logic [INV_W-1:0]   RST_INV_VOXEL    = 24'd655360;
   localparam logic [ROW_W-1:0]   RST_ROT_ROW_A    = 48'h0000_0000_4000;
   localparam logic [ROW_W-1:0]   RST_ROT_ROW_B    = 48'h0000_4000_0000;
   localparam logic [ROW_W-1:0]   RST_ROT_ROW_C    = 48'h4000_0000_0000;
   localparam logic [ROW_W-1:0]   RST_SHIFT_XY     = '0;
   localparam logic [SHIFT_W-1:0] RST_SHIFT_Z      = '0;

endpackage

[design/prgtv_csr.sv]
`timescale 1ns / 1ps

module prgtv_csr
   import prgtv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx        = reg_idx_type'(csr_paddr[CSR_ADDR_W-1 -: REG_IDX_W]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_MIN_RANGE_SQ:   cfg_in.min_range_sq   = csr_pwdata[RANGE_W-1:0];
            REG_MAX_RANGE_SQ:   cfg_in.max_range_sq   = csr_pwdata[RANGE_W-1:0];
            REG_INV_VOXEL_SIZE: cfg_in.inv_voxel_size = csr_pwdata[INV_W-1:0];
            REG_ROT_ROW_A:      cfg_in.rot_rows[0]    = csr_pwdata[ROW_W-1:0];
            REG_ROT_ROW_B:      cfg_in.rot_rows[1]    = csr_pwdata[ROW_W-1:0];
            REG_ROT_ROW_C:      cfg_in.rot_rows[2]    = csr_pwdata[ROW_W-1:0];
            REG_SHIFT_XY:       cfg_in.shift_xy       = csr_pwdata[ROW_W-1:0];
            REG_SHIFT_Z:        cfg_in.shift_z        = csr_pwdata[SHIFT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_range_sq   <= RST_MIN_RANGE_SQ;
         cfg_ff.max_range_sq   <= RST_MAX_RANGE_SQ;
         cfg_ff.inv_voxel_size <= RST_INV_VOXEL;
         cfg_ff.rot_rows[0]    <= RST_ROT_ROW_A;
         cfg_ff.rot_rows[1]    <= RST_ROT_ROW_B;
         cfg_ff.rot_rows[2]    <= RST_ROT_ROW_C;
         cfg_ff.shift_xy       <= RST_SHIFT_XY;
         cfg_ff.shift_z        <= RST_SHIFT_Z;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_MIN_RANGE_SQ:   csr_prdata = CSR_DATA_W'(cfg_ff.min_range_sq);
         REG_MAX_RANGE_SQ:   csr_prdata = CSR_DATA_W'(cfg_ff.max_range_sq);
         REG_INV_VOXEL_SIZE: csr_prdata = CSR_DATA_W'(cfg_ff.inv_voxel_size);
         REG_ROT_ROW_A:      csr_prdata = CSR_DATA_W'(cfg_ff.rot_rows[0]);
         REG_ROT_ROW_B:      csr_prdata = CSR_DATA_W'(cfg_ff.rot_rows[1]);
         REG_ROT_ROW_C:      csr_prdata = CSR_DATA_W'(cfg_ff.rot_rows[2]);
         REG_SHIFT_XY:       csr_prdata = CSR_DATA_W'(cfg_ff.shift_xy);
         REG_SHIFT_Z:        csr_prdata = CSR_DATA_W'(cfg_ff.shift_z);
      endcase
   end

endmodule

[design/prgtv_xform.sv]
`timescale 1ns / 1ps

module prgtv_xform
   import prgtv_pkg::*;
#(
   parameter int COORD_BITS    = 24,
   parameter int ROT_FRAC_BITS = 14
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cfg_type                      cfg,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [COORD_BITS-1:0] in_p [3],
   input  logic signed [NRM_W-1:0]      in_n [3],
   input  logic [WGT_W-1:0]             in_weight,
   input  logic                         in_last,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic                         out_keep,
   output logic signed [COORD_BITS-1:0] out_g [3],
   output logic signed [NRM_W-1:0]      out_gn [3],
   output logic [WGT_W-1:0]             out_weight,
   output logic                         out_last
);

   localparam int PROD_W  = COORD_BITS + ROT_W;
   localparam int NPROD_W = ROT_W + NRM_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int NACC_W  = NPROD_W + 2;
   localparam int SQ_W    = 2 * COORD_BITS;
   localparam int RSQ_W   = SQ_W + 2;
   localparam int CMP_W   = (RSQ_W > RANGE_W) ? RSQ_W : RANGE_W;
   localparam int G_W     = ACC_W + 1;
   localparam int NG_W    = NACC_W + 1;

   localparam logic signed [G_W-1:0]  G_RND = G_W'(2 ** (ROT_FRAC_BITS - 1));
   localparam logic signed [NG_W-1:0] N_RND = NG_W'(2 ** (ROT_FRAC_BITS - 1));
   localparam logic signed [G_W-1:0]  G_HI  = {{(G_W-COORD_BITS+1){1'b0}},
                                               {(COORD_BITS-1){1'b1}}};
   localparam logic signed [G_W-1:0]  G_LO  = {{(G_W-COORD_BITS+1){1'b1}},
                                               {(COORD_BITS-1){1'b0}}};
   localparam logic signed [NG_W-1:0] N_HI  = NG_W'(2 ** ROT_FRAC_BITS);
   localparam logic signed [NG_W-1:0] N_LO  = -N_HI;

   logic load1, load2, load3;
   logic v1_ff, v2_ff, v3_ff;

   logic signed [SHIFT_W-1:0] shift_s [3];

   // stage 1: products
   logic signed [PROD_W-1:0]  pp_ff [3][3];
   logic signed [PROD_W-1:0]  pp_in [3][3];
   logic signed [NPROD_W-1:0] np_ff [3][3];
   logic signed [NPROD_W-1:0] np_in [3][3];
   logic [SQ_W-1:0]           sq_ff [3];
   logic [SQ_W-1:0]           sq_in [3];
   logic [WGT_W-1:0]          w1_ff;
   logic                      l1_ff;

   // stage 2: sums
   logic signed [ACC_W-1:0]   accp_ff [3];
   logic signed [ACC_W-1:0]   accp_in [3];
   logic signed [NACC_W-1:0]  accn_ff [3];
   logic signed [NACC_W-1:0]  accn_in [3];
   logic [RSQ_W-1:0]          rsq_ff;
   logic [RSQ_W-1:0]          rsq_in;
   logic [WGT_W-1:0]          w2_ff;
   logic                      l2_ff;

   // stage 3: round, translate, saturate, gate
   logic                          keep_ff;
   logic                          keep_in;
   logic signed [COORD_BITS-1:0]  g_ff [3];
   logic signed [COORD_BITS-1:0]  g_in [3];
   logic signed [NRM_W-1:0]       gn_ff [3];
   logic signed [NRM_W-1:0]       gn_in [3];
   logic [WGT_W-1:0]              w3_ff;
   logic                          l3_ff;

   assign load3    = !v3_ff || out_ready;
   assign load2    = !v2_ff || load3;
   assign load1    = !v1_ff || load2;
   assign in_ready = load1;

   assign shift_s[0] = $signed(cfg.shift_xy[SHIFT_W-1:0]);
   assign shift_s[1] = $signed(cfg.shift_xy[ROW_W-1:SHIFT_W]);
   assign shift_s[2] = $signed(cfg.shift_z);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pp_in[i][j] = PROD_W'($signed(cfg.rot_rows[i][ROT_W*j +: ROT_W]))
                          * PROD_W'(in_p[j]);
            np_in[i][j] = NPROD_W'($signed(cfg.rot_rows[i][ROT_W*j +: ROT_W]))
                          * NPROD_W'(in_n[j]);
         end
         sq_in[i] = $unsigned(SQ_W'(in_p[i]) * SQ_W'(in_p[i]));
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         accp_in[i] = ACC_W'(pp_ff[i][0]) + ACC_W'(pp_ff[i][1]) + ACC_W'(pp_ff[i][2]);
         accn_in[i] = NACC_W'(np_ff[i][0]) + NACC_W'(np_ff[i][1])
                      + NACC_W'(np_ff[i][2]);
      end
      rsq_in = RSQ_W'(sq_ff[0]) + RSQ_W'(sq_ff[1]) + RSQ_W'(sq_ff[2]);
   end

   always_comb begin
      logic signed [G_W-1:0]  gs;
      logic signed [NG_W-1:0] ns;
      keep_in = (CMP_W'(rsq_ff) >= CMP_W'(cfg.min_range_sq))
                && (CMP_W'(rsq_ff) <= CMP_W'(cfg.max_range_sq));
      for (int i = 0; i < 3; i++) begin
         gs = ((G_W'(accp_ff[i]) + G_RND) >>> ROT_FRAC_BITS) + G_W'(shift_s[i]);
         ns = (NG_W'(accn_ff[i]) + N_RND) >>> ROT_FRAC_BITS;
         priority if (gs > G_HI) begin
            g_in[i] = G_HI[COORD_BITS-1:0];
         end else if (gs < G_LO) begin
            g_in[i] = G_LO[COORD_BITS-1:0];
         end else begin
            g_in[i] = gs[COORD_BITS-1:0];
         end
         priority if (ns > N_HI) begin
            gn_in[i] = N_HI[NRM_W-1:0];
         end else if (ns < N_LO) begin
            gn_in[i] = N_LO[NRM_W-1:0];
         end else begin
            gn_in[i] = ns[NRM_W-1:0];
         end
         if (!keep_in) begin
            g_in[i]  = '0;
            gn_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (load1) begin
            v1_ff <= in_valid;
         end
         if (load2) begin
            v2_ff <= v1_ff;
         end
         if (load3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         pp_ff <= pp_in;
         np_ff <= np_in;
         sq_ff <= sq_in;
         w1_ff <= in_weight;
         l1_ff <= in_last;
      end
      if (load2) begin
         accp_ff <= accp_in;
         accn_ff <= accn_in;
         rsq_ff  <= rsq_in;
         w2_ff   <= w1_ff;
         l2_ff   <= l1_ff;
      end
      if (load3) begin
         keep_ff <= keep_in;
         g_ff    <= g_in;
         gn_ff   <= gn_in;
         w3_ff   <= w2_ff;
         l3_ff   <= l2_ff;
      end
   end

   assign out_valid  = v3_ff;
   assign out_keep   = keep_ff;
   assign out_g      = g_ff;
   assign out_gn     = gn_ff;
   assign out_weight = w3_ff;
   assign out_last   = l3_ff;

endmodule

[design/prgtv_voxel.sv]
`timescale 1ns / 1ps

module prgtv_voxel
   import prgtv_pkg::*;
#(
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [INV_W-1:0]             inv_voxel_size,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         in_keep,
   input  logic signed [COORD_BITS-1:0] in_g [3],
   input  logic signed [NRM_W-1:0]      in_gn [3],
   input  logic [WGT_W-1:0]             in_weight,
   input  logic                         in_last,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic                         out_keep,
   output logic signed [COORD_BITS-1:0] out_key [3],
   output logic signed [COORD_BITS-1:0] out_g [3],
   output logic signed [NRM_W-1:0]      out_gn [3],
   output logic [WGT_W-1:0]             out_weight,
   output logic                         out_last
);

   localparam int KP_W = COORD_BITS + INV_W + 1;

   localparam logic signed [KP_W-1:0] K_HI = {{(KP_W-COORD_BITS+1){1'b0}},
                                              {(COORD_BITS-1){1'b1}}};
   localparam logic signed [KP_W-1:0] K_LO = {{(KP_W-COORD_BITS+1){1'b1}},
                                              {(COORD_BITS-1){1'b0}}};

   logic load4, load5;
   logic v4_ff, v5_ff;

   // stage 4: scale by reciprocal
   logic signed [KP_W-1:0]       kp_ff [3];
   logic signed [KP_W-1:0]       kp_in [3];
   logic                         keep4_ff;
   logic signed [COORD_BITS-1:0] g4_ff [3];
   logic signed [NRM_W-1:0]      gn4_ff [3];
   logic [WGT_W-1:0]             w4_ff;
   logic                         l4_ff;

   // stage 5: floor, saturate, output register
   logic signed [COORD_BITS-1:0] key_ff [3];
   logic signed [COORD_BITS-1:0] key_in [3];
   logic                         keep5_ff;
   logic signed [COORD_BITS-1:0] g5_ff [3];
   logic signed [NRM_W-1:0]      gn5_ff [3];
   logic [WGT_W-1:0]             w5_ff;
   logic                         l5_ff;

   assign load5    = !v5_ff || out_ready;
   assign load4    = !v4_ff || load5;
   assign in_ready = load4;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         kp_in[i] = KP_W'(in_g[i]) * KP_W'($signed({1'b0, inv_voxel_size}));
      end
   end

   always_comb begin
      logic signed [KP_W-1:0] ks;
      for (int i = 0; i < 3; i++) begin
         ks = kp_ff[i] >>> INV_W;
         priority if (ks > K_HI) begin
            key_in[i] = K_HI[COORD_BITS-1:0];
         end else if (ks < K_LO) begin
            key_in[i] = K_LO[COORD_BITS-1:0];
         end else begin
            key_in[i] = ks[COORD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (load4) begin
            v4_ff <= in_valid;
         end
         if (load5) begin
            v5_ff <= v4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load4) begin
         kp_ff    <= kp_in;
         keep4_ff <= in_keep;
         g4_ff    <= in_g;
         gn4_ff   <= in_gn;
         w4_ff    <= in_weight;
         l4_ff    <= in_last;
      end
      if (load5) begin
         key_ff   <= key_in;
         keep5_ff <= keep4_ff;
         g5_ff    <= g4_ff;
         gn5_ff   <= gn4_ff;
         w5_ff    <= w4_ff;
         l5_ff    <= l4_ff;
      end
   end

   assign out_valid  = v5_ff;
   assign out_keep   = keep5_ff;
   assign out_key    = key_ff;
   assign out_g      = g5_ff;
   assign out_gn     = gn5_ff;
   assign out_weight = w5_ff;
   assign out_last   = l5_ff;

endmodule

[design/point_range_gate_transform_voxelize.sv]
// Throughput: one beat per cycle while rsp_tready is high; five register
// stages (products, sums, round and gate, voxel scaling, output) each hold
// one beat and stall in place.
// Reset: synchronous, active high; empties the pipeline and loads the
// registers with their defaults (identity rotation, no shift, 10 voxels/m).
`timescale 1ns / 1ps

module point_range_gate_transform_voxelize
   import prgtv_pkg::*;
#(
   parameter int COORD_BITS    = 24,
   parameter int ROT_FRAC_BITS = 14
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              req_tvalid,
   output logic                                              req_tready,
   // px, py, pz, nx, ny, nz, pt_weight
   input  logic [((3*COORD_BITS+3*NRM_W+WGT_W+7)/8)*8-1:0]   req_tdata,
   input  logic                                              req_tlast,
   output logic                                              rsp_tvalid,
   input  logic                                              rsp_tready,
   // key_x, key_y, key_z, gx, gy, gz, gnx, gny, gnz, out_weight
   output logic [((6*COORD_BITS+3*NRM_W+WGT_W+7)/8)*8-1:0]   rsp_tdata,
   // kept
   output logic [0:0]                                        rsp_tuser,
   output logic                                              rsp_tlast,
   input  logic                                              csr_psel,
   input  logic                                              csr_penable,
   input  logic                                              csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]                             csr_paddr,
   input  logic [CSR_DATA_W-1:0]                             csr_pwdata,
   output logic [CSR_DATA_W-1:0]                             csr_prdata,
   output logic                                              csr_pready
);

   localparam int RSP_DATA_W = ((6*COORD_BITS+3*NRM_W+WGT_W+7)/8)*8;
   localparam int NRM_BASE   = 3 * COORD_BITS;
   localparam int WGT_BASE   = NRM_BASE + 3 * NRM_W;

   cfg_type cfg;

   logic signed [COORD_BITS-1:0] req_p [3];
   logic signed [NRM_W-1:0]      req_n [3];

   logic                         xv_valid;
   logic                         xv_ready;
   logic                         xv_keep;
   logic signed [COORD_BITS-1:0] xv_g [3];
   logic signed [NRM_W-1:0]      xv_gn [3];
   logic [WGT_W-1:0]             xv_weight;
   logic                         xv_last;

   logic                         o_keep;
   logic signed [COORD_BITS-1:0] o_key [3];
   logic signed [COORD_BITS-1:0] o_g [3];
   logic signed [NRM_W-1:0]      o_gn [3];
   logic [WGT_W-1:0]             o_weight;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         req_p[i] = $signed(req_tdata[COORD_BITS*i +: COORD_BITS]);
         req_n[i] = $signed(req_tdata[NRM_BASE + NRM_W*i +: NRM_W]);
      end
   end

   prgtv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   prgtv_xform #(
      .COORD_BITS    (COORD_BITS),
      .ROT_FRAC_BITS (ROT_FRAC_BITS)
   ) u_xform (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_p       (req_p),
      .in_n       (req_n),
      .in_weight  (req_tdata[WGT_BASE +: WGT_W]),
      .in_last    (req_tlast),
      .out_valid  (xv_valid),
      .out_ready  (xv_ready),
      .out_keep   (xv_keep),
      .out_g      (xv_g),
      .out_gn     (xv_gn),
      .out_weight (xv_weight),
      .out_last   (xv_last)
   );

   prgtv_voxel #(
      .COORD_BITS (COORD_BITS)
   ) u_voxel (
      .clock          (clock),
      .reset          (reset),
      .inv_voxel_size (cfg.inv_voxel_size),
      .in_valid       (xv_valid),
      .in_ready       (xv_ready),
      .in_keep        (xv_keep),
      .in_g           (xv_g),
      .in_gn          (xv_gn),
      .in_weight      (xv_weight),
      .in_last        (xv_last),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_keep       (o_keep),
      .out_key        (o_key),
      .out_g          (o_g),
      .out_gn         (o_gn),
      .out_weight     (o_weight),
      .out_last       (rsp_tlast)
   );

   assign rsp_tuser[0] = o_keep;
   assign rsp_tdata    = RSP_DATA_W'({o_weight, o_gn[2], o_gn[1], o_gn[0],
                                      o_g[2], o_g[1], o_g[0],
                                      o_key[2], o_key[1], o_key[0]});

endmodule

[design/prgtv_checker.sv]
`timescale 1ns / 1ps
`include "point_range_gate_transform_voxelize_macros.svh"

module prgtv_checker #(
   parameter int COORD_BITS = 24
) (
   input logic                                       clock,
   input logic                                       reset,
   input logic                                       req_tready,
   input logic                                       rsp_tvalid,
   input logic                                       rsp_tready,
   input logic [((6*COORD_BITS+64+7)/8)*8-1:0]       rsp_tdata,
   input logic [0:0]                                 rsp_tuser
);

   localparam int FIELD_W = 6 * COORD_BITS + 48;

   `PRGTV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp beat dropped while stalled")
   `PRGTV_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser), "rsp beat changed while stalled")
   `PRGTV_ASSERT_NOW(a_drop_zero, clock, reset, rsp_tvalid && (rsp_tuser[0] == 1'b0), rsp_tdata[FIELD_W-1:0] == '0, "dropped point carries nonzero fields")
   `PRGTV_ASSERT_NOW(a_no_backpressure, clock, reset, rsp_tready, req_tready, "req stalled with rsp side ready")
   `PRGTV_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid, "rsp valid right after reset")

endmodule

bind point_range_gate_transform_voxelize prgtv_checker #(
   .COORD_BITS (COORD_BITS)
) u_prgtv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[dv/point_range_gate_transform_voxelize_tb.sv]
`timescale 1ns / 1ps

module point_range_gate_transform_voxelize_tb
   import prgtv_pkg::*;
();

   localparam int CRD_W       = 24;
   localparam int FRAC_W      = 14;
   localparam int REQ_W       = ((3*CRD_W+3*NRM_W+WGT_W+7)/8)*8;
   localparam int RSP_W       = ((6*CRD_W+3*NRM_W+WGT_W+7)/8)*8;
   localparam longint CRD_MAX = (longint'(1) << (CRD_W-1)) - 1;
   localparam longint CRD_MIN = -(longint'(1) << (CRD_W-1));
   localparam longint NRM_LIM = longint'(1) << FRAC_W;
   localparam int CYCLE_LIMIT = 300000;

   typedef struct {
      logic signed [CRD_W-1:0] px, py, pz;
      logic signed [NRM_W-1:0] nx, ny, nz;
      logic [WGT_W-1:0]        weight;
      logic                    scan_end;
   } point_type;

   typedef struct packed {
      logic                        kept;
      logic [2:0][CRD_W-1:0]       key;
      logic [2:0][CRD_W-1:0]       g;
      logic [2:0][NRM_W-1:0]       gn;
      logic [WGT_W-1:0]            weight;
      logic                        scan_end;
   } voxel_result_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata   = '0;
   logic                  req_tlast   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // register image
   logic [RANGE_W-1:0] cfg_min_sq   = RST_MIN_RANGE_SQ;
   logic [RANGE_W-1:0] cfg_max_sq   = RST_MAX_RANGE_SQ;
   logic [INV_W-1:0]   cfg_inv      = RST_INV_VOXEL;
   logic [ROW_W-1:0]   cfg_rows [3] = '{RST_ROT_ROW_A, RST_ROT_ROW_B, RST_ROT_ROW_C};
   logic [ROW_W-1:0]   cfg_shift_xy = RST_SHIFT_XY;
   logic [SHIFT_W-1:0] cfg_shift_z  = RST_SHIFT_Z;

   voxel_result_type expected_voxels [$];
   int unsigned   fail_count    = 0;
   int unsigned   cycle_count   = 0;
   int            rsp_hold_left = 0;
   int            rsp_gap_left  = 0;
   bit            rsp_stalls_on = 1'b1;
   bit            req_stalls_on = 1'b1;

   point_range_gate_transform_voxelize u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      // px, py, pz, nx, ny, nz, pt_weight
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      // key_x, key_y, key_z, gx, gy, gz, gnx, gny, gnz, out_weight
      .rsp_tdata   (rsp_tdata),
      // kept
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic voxel_result_type transform_point(point_type pt);
      voxel_result_type res;
      longint pos [3];
      longint nrm [3];
      longint shift [3];
      longint rsq, acc_p, acc_n, entry, gl, gnl, kl;
      bit keep;
      pos[0] = pt.px;
      pos[1] = pt.py;
      pos[2] = pt.pz;
      nrm[0] = pt.nx;
      nrm[1] = pt.ny;
      nrm[2] = pt.nz;
      shift[0] = $signed(cfg_shift_xy[23:0]);
      shift[1] = $signed(cfg_shift_xy[47:24]);
      shift[2] = $signed(cfg_shift_z);
      rsq = pos[0]*pos[0] + pos[1]*pos[1] + pos[2]*pos[2];
      keep = (rsq >= longint'(cfg_min_sq)) && (rsq <= longint'(cfg_max_sq));
      res = '0;
      res.kept = keep;
      res.weight = pt.weight;
      res.scan_end = pt.scan_end;
      for (int i = 0; i < 3; i++) begin
         acc_p = 0;
         acc_n = 0;
         for (int j = 0; j < 3; j++) begin
            entry = $signed(cfg_rows[i][16*j +: 16]);
            acc_p += entry * pos[j];
            acc_n += entry * nrm[j];
         end
         // round half up, then saturate
         gl = ((acc_p + (longint'(1) << (FRAC_W-1))) >>> FRAC_W) + shift[i];
         if (gl > CRD_MAX) gl = CRD_MAX;
         else if (gl < CRD_MIN) gl = CRD_MIN;
         gnl = (acc_n + (longint'(1) << (FRAC_W-1))) >>> FRAC_W;
         if (gnl > NRM_LIM) gnl = NRM_LIM;
         else if (gnl < -NRM_LIM) gnl = -NRM_LIM;
         kl = (gl * longint'(cfg_inv)) >>> 24;
         if (kl > CRD_MAX) kl = CRD_MAX;
         else if (kl < CRD_MIN) kl = CRD_MIN;
         if (keep) begin
            res.key[i] = kl[CRD_W-1:0];
            res.g[i]   = gl[CRD_W-1:0];
            res.gn[i]  = gnl[NRM_W-1:0];
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch %s: expected %h, got %h", what, want, got);
   endtask

   always @(posedge clock) begin
      voxel_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kept = rsp_tuser[0];
         for (int i = 0; i < 3; i++) begin
            got.key[i] = rsp_tdata[CRD_W*i +: CRD_W];
            got.g[i]   = rsp_tdata[3*CRD_W + CRD_W*i +: CRD_W];
            got.gn[i]  = rsp_tdata[6*CRD_W + NRM_W*i +: NRM_W];
         end
         got.weight   = rsp_tdata[6*CRD_W + 3*NRM_W +: WGT_W];
         got.scan_end = rsp_tlast;
         if (expected_voxels.size() == 0) begin
            report_mismatch("result beat with nothing pending", '0, got.kept);
         end else begin
            want = expected_voxels.pop_front();
            if (got.kept !== want.kept) report_mismatch("kept", want.kept, got.kept);
            for (int i = 0; i < 3; i++) begin
               if (got.key[i] !== want.key[i])
                  report_mismatch($sformatf("key[%0d]", i), want.key[i], got.key[i]);
               if (got.g[i] !== want.g[i])
                  report_mismatch($sformatf("g[%0d]", i), want.g[i], got.g[i]);
               if (got.gn[i] !== want.gn[i])
                  report_mismatch($sformatf("gn[%0d]", i), want.gn[i], got.gn[i]);
            end
            if (got.weight !== want.weight)
               report_mismatch("weight", want.weight, got.weight);
            if (got.scan_end !== want.scan_end)
               report_mismatch("scan_end", want.scan_end, got.scan_end);
         end
      end
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(15, 60);
      return $urandom_range(1, 3);
   endfunction

   // receiver back-pressure
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else if (!rsp_stalls_on) begin
         rsp_tready <= 1'b1;
      end else if (rsp_gap_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap_left = rsp_gap_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         rsp_gap_left = pick_gap() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_point(point_type pt);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {pt.weight, pt.nz, pt.ny, pt.nx, pt.pz, pt.py, pt.px};
      req_tlast  <= pt.scan_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_voxels.insert(expected_voxels.size(), transform_point(pt));
   endtask

   task automatic req_idle(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic wait_drained();
      req_idle(1);
      while (expected_voxels.size() != 0) @(posedge clock);
   endtask

   task automatic csr_readback(reg_idx_type idx);
      logic [63:0] want, mask;
      int width;
      case (idx)
         REG_MIN_RANGE_SQ:   begin want = cfg_min_sq;   width = RANGE_W; end
         REG_MAX_RANGE_SQ:   begin want = cfg_max_sq;   width = RANGE_W; end
         REG_INV_VOXEL_SIZE: begin want = cfg_inv;      width = INV_W;   end
         REG_ROT_ROW_A:      begin want = cfg_rows[0];  width = ROW_W;   end
         REG_ROT_ROW_B:      begin want = cfg_rows[1];  width = ROW_W;   end
         REG_ROT_ROW_C:      begin want = cfg_rows[2];  width = ROW_W;   end
         REG_SHIFT_XY:       begin want = cfg_shift_xy; width = ROW_W;   end
         default:            begin want = cfg_shift_z;  width = SHIFT_W; end
      endcase
      mask = (64'd1 << width) - 64'd1;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 3'b000};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if ((csr_prdata & mask) !== (want & mask))
         report_mismatch($sformatf("register %s", idx.name()), want & mask, csr_prdata & mask);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_write(reg_idx_type idx, logic [63:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_MIN_RANGE_SQ:   cfg_min_sq   = value[RANGE_W-1:0];
         REG_MAX_RANGE_SQ:   cfg_max_sq   = value[RANGE_W-1:0];
         REG_INV_VOXEL_SIZE: cfg_inv      = value[INV_W-1:0];
         REG_ROT_ROW_A:      cfg_rows[0]  = value[ROW_W-1:0];
         REG_ROT_ROW_B:      cfg_rows[1]  = value[ROW_W-1:0];
         REG_ROT_ROW_C:      cfg_rows[2]  = value[ROW_W-1:0];
         REG_SHIFT_XY:       cfg_shift_xy = value[ROW_W-1:0];
         default:            cfg_shift_z  = value[SHIFT_W-1:0];
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_readback(idx);
   endtask

   task automatic write_all_regs(logic [63:0] min_sq, logic [63:0] max_sq, logic [63:0] inv,
                                 logic [63:0] row_a, logic [63:0] row_b, logic [63:0] row_c,
                                 logic [63:0] shift_xy, logic [63:0] shift_z);
      wait_drained();
      csr_write(REG_MIN_RANGE_SQ, min_sq);
      csr_write(REG_MAX_RANGE_SQ, max_sq);
      csr_write(REG_INV_VOXEL_SIZE, inv);
      csr_write(REG_ROT_ROW_A, row_a);
      csr_write(REG_ROT_ROW_B, row_b);
      csr_write(REG_ROT_ROW_C, row_c);
      csr_write(REG_SHIFT_XY, shift_xy);
      csr_write(REG_SHIFT_Z, shift_z);
   endtask

   function automatic point_type mk_point(int px, int py, int pz, int nx, int ny, int nz,
                                          int weight, bit scan_end);
      point_type pt;
      pt.px = px;
      pt.py = py;
      pt.pz = pz;
      pt.nx = nx;
      pt.ny = ny;
      pt.nz = nz;
      pt.weight = weight;
      pt.scan_end = scan_end;
      return pt;
   endfunction

   // spread magnitudes over every bit width
   function automatic logic signed [CRD_W-1:0] rand_coord();
      int w;
      logic [31:0] v;
      w = $urandom_range(1, CRD_W);
      v = $urandom & ((32'd1 << w) - 32'd1);
      return v - (32'd1 << (w - 1));
   endfunction

   function automatic logic signed [NRM_W-1:0] rand_normal();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return $urandom_range(0, 32768) - 16384;
   endfunction

   function automatic point_type rand_point();
      point_type pt;
      pt.px = rand_coord();
      pt.py = rand_coord();
      pt.pz = rand_coord();
      pt.nx = rand_normal();
      pt.ny = rand_normal();
      pt.nz = rand_normal();
      pt.weight = $urandom;
      pt.scan_end = ($urandom_range(0, 7) == 0);
      return pt;
   endfunction

   function automatic logic [15:0] rand_rot_entry(bit extreme);
      if (extreme) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      if ($urandom_range(0, 7) == 0) return $urandom;
      return $urandom_range(0, 32768) - 16384;
   endfunction

   function automatic logic [63:0] rand_row(bit extreme);
      return {16'h0, rand_rot_entry(extreme), rand_rot_entry(extreme), rand_rot_entry(extreme)};
   endfunction

   task automatic test_defaults();
      for (int i = 0; i < 8; i++) csr_readback(reg_idx_type'(i));
      send_point(mk_point(0, 0, 0, 0, 0, 0, 0, 1'b0));
      send_point(mk_point(8388607, -8388608, 8388607, 16384, -16384, 16384, 65535, 1'b1));
      send_point(mk_point(-8388608, -8388608, -8388608, -32768, 32767, 0, 1, 1'b0));
      send_point(mk_point(-1, 1, -300, 1, -1, 8191, 32768, 1'b1));
   endtask

   task automatic test_range_gate();
      write_all_regs(10000, 20000, RST_INV_VOXEL, RST_ROT_ROW_A, RST_ROT_ROW_B,
                     RST_ROT_ROW_C, 0, 0);
      send_point(mk_point(100, 0, 0, 100, 0, 0, 11, 1'b0));   // on the lower bound
      send_point(mk_point(99, 0, 0, 100, 0, 0, 12, 1'b1));    // just inside the hole
      send_point(mk_point(100, 100, 0, 0, 100, 0, 13, 1'b0)); // on the upper bound
      send_point(mk_point(100, 100, 1, 0, 0, 100, 14, 1'b1)); // just beyond
      send_point(mk_point(0, 0, -100, 0, 0, -100, 15, 1'b0));
      // inverted bounds drop everything
      wait_drained();
      csr_write(REG_MIN_RANGE_SQ, 20001);
      send_point(mk_point(100, 100, 0, 0, 100, 0, 16, 1'b0));
      send_point(mk_point(0, 0, 0, 0, 0, 0, 17, 1'b1));
   endtask

   task automatic test_zero_reciprocal();
      write_all_regs(RST_MIN_RANGE_SQ, RST_MAX_RANGE_SQ, 0, RST_ROT_ROW_A, RST_ROT_ROW_B,
                     RST_ROT_ROW_C, {24'h000123, 24'hFFFF00}, 24'h000040);
      send_point(mk_point(1000, -1000, 5, 300, -300, 50, 100, 1'b0));
      send_point(mk_point(-8388608, 8388607, -1, -16384, 16384, -1, 200, 1'b1));
   endtask

   task automatic test_saturation();
      write_all_regs(RST_MIN_RANGE_SQ, RST_MAX_RANGE_SQ, 24'hFFFFFF, 48'h7FFF_7FFF_7FFF,
                     48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, {24'h7FFFFF, 24'h7FFFFF},
                     24'h800000);
      send_point(mk_point(8388607, 8388607, 8388607, 16384, 16384, 16384, 65535, 1'b1));
      send_point(mk_point(-8388608, -8388608, -8388608, -32768, -32768, -32768, 0, 1'b0));
      send_point(mk_point(3, -2, 1, 1, 0, -1, 4, 1'b0));
      wait_drained();
      csr_write(REG_ROT_ROW_A, 48'h8000_8000_8000);
      csr_write(REG_ROT_ROW_B, 48'h8000_8000_8000);
      csr_write(REG_ROT_ROW_C, 48'h8000_8000_8000);
      send_point(mk_point(8388607, 8388607, 8388607, 32767, 32767, 32767, 9, 1'b1));
   endtask

   task automatic test_random_sweep();
      logic [63:0] r1, r2;
      bit extreme;
      for (int phase = 0; phase < 6; phase++) begin
         extreme = (phase == 5);
         r1 = {$urandom, $urandom};
         r2 = {$urandom, $urandom};
         if (extreme)
            write_all_regs(0, RST_MAX_RANGE_SQ, 24'hFFFFFF, rand_row(1'b1), rand_row(1'b1),
                           rand_row(1'b1), {rand_coord(), rand_coord()}, rand_coord());
         else
            write_all_regs(r1[RANGE_W-1:0] >> $urandom_range(6, 46),
                           r2[RANGE_W-1:0] >> $urandom_range(0, 14),
                           (phase == 4) ? 1 : ($urandom_range(1, 24'hFFFFFF) >>
                                               $urandom_range(0, 16)),
                           rand_row(1'b0), rand_row(1'b0), rand_row(1'b0),
                           {rand_coord(), rand_coord()}, rand_coord());
         // one phase runs flat out on both sides
         rsp_stalls_on = (phase != 1);
         req_stalls_on = (phase != 1);
         for (int n = 0; n < 160; n++) begin
            send_point(rand_point());
            if (req_stalls_on && $urandom_range(0, 4) == 0) req_idle(pick_gap());
         end
      end
      rsp_stalls_on = 1'b1;
      req_stalls_on = 1'b1;
   endtask

   task automatic test_rsp_hold();
      wait_drained();
      rsp_hold_left = 300;
      for (int n = 0; n < 40; n++) send_point(rand_point());
   endtask

   task automatic test_req_pause();
      for (int n = 0; n < 30; n++) begin
         send_point(rand_point());
         if ($urandom_range(0, 3) == 0) req_idle(pick_gap());
      end
      wait_drained();
      for (int n = 0; n < 30; n++) send_point(rand_point());
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      test_defaults();
      test_range_gate();
      test_zero_reciprocal();
      test_saturation();
      test_random_sweep();
      test_rsp_hold();
      test_req_pause();
      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
